>>> hw/rtl/aet_pkg.sv
// types and constants shared by the tokenizer front end, run queue and output stage
// no dependencies
`default_nettype none

package aet_pkg;

   typedef enum logic [3:0] {
      KIND_NUMBER  = 4'd0,
      KIND_LPAREN  = 4'd1,
      KIND_RPAREN  = 4'd2,
      KIND_PLUS    = 4'd3,
      KIND_MINUS   = 4'd4,
      KIND_MUL     = 4'd5,
      KIND_DIV     = 4'd6,
      KIND_POW     = 4'd7,
      KIND_SIN     = 4'd8,
      KIND_COS     = 4'd9,
      KIND_TAN     = 4'd10,
      KIND_UNKNOWN = 4'd11,
      KIND_END     = 4'd12
   } kind_type;

   localparam int RUN_SLOTS        = 3;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [4:0]  length;
   } tok_type;

   // all tokens caused by one character; a number token only ever sits in slot 0
   typedef struct packed {
      logic [1:0]                count;
      tok_type [RUN_SLOTS-1:0]   tok;
      logic [63:0]               mantissa;
      logic [4:0]                fraction;
      logic                      saturated;
   } run_type;

endpackage

`default_nettype wire

>>> hw/rtl/aet_front.sv
// character scanner: classifies one character per accepted item and builds the run of tokens
// depends on aet_pkg
`default_nettype none

module aet_front #(
   parameter int MAX_LEXEME    = 32,
   parameter int POSITION_BITS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      char_code,
   output aet_pkg::run_type     run,
   output logic                 run_push
);

   localparam int CW = $clog2(MAX_LEXEME);
   localparam logic [CW-1:0] LEX_LIMIT     = CW'(MAX_LEXEME - 1);
   localparam logic [CW-1:0] LEX_DOT_LIMIT = CW'(MAX_LEXEME - 2);

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;

   localparam logic [23:0] WORD_SIN = 24'h73696E;
   localparam logic [23:0] WORD_COS = 24'h636F73;
   localparam logic [23:0] WORD_TAN = 24'h74616E;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_INT,
      MODE_DOTWAIT,
      MODE_LEADDOT,
      MODE_FRAC,
      MODE_ALPHA,
      MODE_UNK
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic [POSITION_BITS-1:0] begin_pos;
      logic [CW-1:0]            cnt;
      logic [15:0]              prefix;
      logic [63:0]              mant;
      logic [CW-1:0]            frac;
      logic                     ovf;
   } scan_type;

   function automatic aet_pkg::tok_type mk_tok(aet_pkg::kind_type k,
                                               logic [POSITION_BITS-1:0] s,
                                               logic [CW-1:0] l);
      aet_pkg::tok_type t;
      t.kind   = k;
      t.start  = 16'(s);
      t.length = 5'(l);
      return t;
   endfunction

   scan_type                 scan_ff, scan_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] pos_prev;

   logic                     is_digit, is_letter, is_blank_end;
   logic [3:0]               digit;
   logic                     sym_valid;
   aet_pkg::kind_type        sym_kind;
   logic                     word_valid;
   aet_pkg::kind_type        word_kind;
   logic [23:0]              word;

   scan_type                 restart;
   logic                     r_valid, r_end;
   aet_pkg::tok_type         r_tok;

   logic [67:0]              acc_wide;
   logic                     acc_sat;
   logic [63:0]              acc_mant;

   logic                     line_end, unk_path;
   logic [1:0]               tok_count;
   aet_pkg::tok_type         tok0, tok1, tok2;
   logic [CW-1:0]            cnt_plus;

   assign is_digit     = (char_code >= 8'h30) && (char_code <= 8'h39);
   assign is_letter    = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                         ((char_code >= 8'h41) && (char_code <= 8'h5A));
   assign is_blank_end = (char_code == CHAR_NUL) || (char_code == CHAR_SPACE);
   assign digit        = char_code[3:0];
   assign pos_prev     = pos_ff - POSITION_BITS'(1);
   assign cnt_plus     = scan_ff.cnt + CW'(1);
   assign word         = {scan_ff.prefix, char_code};

   always_comb begin
      sym_valid = 1'b1;
      case (char_code)
         CHAR_LPAREN: sym_kind = aet_pkg::KIND_LPAREN;
         CHAR_RPAREN: sym_kind = aet_pkg::KIND_RPAREN;
         CHAR_PLUS:   sym_kind = aet_pkg::KIND_PLUS;
         CHAR_MINUS:  sym_kind = aet_pkg::KIND_MINUS;
         CHAR_STAR:   sym_kind = aet_pkg::KIND_MUL;
         CHAR_SLASH:  sym_kind = aet_pkg::KIND_DIV;
         CHAR_CARET:  sym_kind = aet_pkg::KIND_POW;
         default: begin
            sym_valid = 1'b0;
            sym_kind  = aet_pkg::KIND_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      word_valid = 1'b1;
      case (word)
         WORD_SIN: word_kind = aet_pkg::KIND_SIN;
         WORD_COS: word_kind = aet_pkg::KIND_COS;
         WORD_TAN: word_kind = aet_pkg::KIND_TAN;
         default: begin
            word_valid = 1'b0;
            word_kind  = aet_pkg::KIND_UNKNOWN;
         end
      endcase
   end

   // mantissa times ten plus digit, saturating
   assign acc_wide = ({4'b0, scan_ff.mant} << 3) + ({4'b0, scan_ff.mant} << 1) + 68'(digit);
   assign acc_sat  = scan_ff.ovf | (|acc_wide[67:64]);
   assign acc_mant = acc_sat ? {64{1'b1}} : acc_wide[63:0];

   // what the current character does when scanning starts over at it
   always_comb begin
      restart           = '0;
      restart.mode      = MODE_IDLE;
      restart.begin_pos = pos_ff;
      r_valid           = 1'b0;
      r_end             = 1'b0;
      r_tok             = '0;
      if (char_code == CHAR_NUL) begin
         r_valid = 1'b1;
         r_end   = 1'b1;
         r_tok   = mk_tok(aet_pkg::KIND_END, pos_ff, '0);
      end else if (char_code == CHAR_SPACE) begin
         restart.mode = MODE_IDLE;
      end else if (is_digit) begin
         restart.mode = MODE_INT;
         restart.cnt  = CW'(1);
         restart.mant = 64'(digit);
      end else if (char_code == CHAR_DOT) begin
         restart.mode = MODE_LEADDOT;
         restart.cnt  = CW'(1);
      end else if (sym_valid) begin
         r_valid = 1'b1;
         r_tok   = mk_tok(sym_kind, pos_ff, CW'(1));
      end else if (is_letter) begin
         restart.mode   = MODE_ALPHA;
         restart.cnt    = CW'(1);
         restart.prefix = 16'(char_code);
      end else begin
         restart.mode = MODE_UNK;
         restart.cnt  = CW'(1);
      end
   end

   always_comb begin
      scan_in   = scan_ff;
      line_end  = 1'b0;
      unk_path  = 1'b0;
      tok_count = 2'd0;
      tok0      = '0;
      tok1      = '0;
      tok2      = '0;
      case (scan_ff.mode)
         MODE_IDLE: begin
            scan_in   = restart;
            line_end  = r_end;
            tok0      = r_tok;
            tok_count = {1'b0, r_valid};
         end
         MODE_INT, MODE_FRAC: begin
            if (is_digit) begin
               if (scan_ff.cnt >= LEX_LIMIT) begin
                  tok0      = mk_tok(aet_pkg::KIND_UNKNOWN, scan_ff.begin_pos, LEX_LIMIT);
                  tok_count = 2'd1;
                  scan_in   = restart;
               end else begin
                  scan_in.mant = acc_mant;
                  scan_in.ovf  = acc_sat;
                  scan_in.cnt  = cnt_plus;
                  if (scan_ff.mode == MODE_FRAC) begin
                     scan_in.frac = scan_ff.frac + CW'(1);
                  end
               end
            end else if (char_code == CHAR_DOT && scan_ff.mode == MODE_INT) begin
               scan_in.mode = MODE_DOTWAIT;
            end else begin
               tok0      = mk_tok(aet_pkg::KIND_NUMBER, scan_ff.begin_pos, scan_ff.cnt);
               tok1      = r_tok;
               tok_count = 2'd1 + {1'b0, r_valid};
               scan_in   = restart;
               line_end  = r_end;
            end
         end
         MODE_DOTWAIT: begin
            if (is_digit) begin
               if (scan_ff.cnt < LEX_DOT_LIMIT) begin
                  scan_in.mant = acc_mant;
                  scan_in.ovf  = acc_sat;
                  scan_in.frac = CW'(1);
                  scan_in.cnt  = scan_ff.cnt + CW'(2);
                  scan_in.mode = MODE_FRAC;
               end else if (scan_ff.cnt < LEX_LIMIT) begin
                  tok0      = mk_tok(aet_pkg::KIND_UNKNOWN, scan_ff.begin_pos, LEX_LIMIT);
                  tok_count = 2'd1;
                  scan_in   = restart;
               end else begin
                  // digits alone filled the lexeme: the dot starts a fraction of its own
                  tok0              = mk_tok(aet_pkg::KIND_UNKNOWN, scan_ff.begin_pos, LEX_LIMIT);
                  tok_count         = 2'd1;
                  scan_in           = '0;
                  scan_in.mode      = MODE_FRAC;
                  scan_in.begin_pos = pos_prev;
                  scan_in.cnt       = CW'(2);
                  scan_in.mant      = 64'(digit);
                  scan_in.frac      = CW'(1);
               end
            end else begin
               tok0 = mk_tok(aet_pkg::KIND_NUMBER, scan_ff.begin_pos, scan_ff.cnt);
               if (is_blank_end) begin
                  tok1      = mk_tok(aet_pkg::KIND_UNKNOWN, pos_prev, CW'(1));
                  tok2      = r_tok;
                  tok_count = 2'd2 + {1'b0, r_valid};
                  scan_in   = restart;
                  line_end  = r_end;
               end else begin
                  tok_count         = 2'd1;
                  scan_in           = '0;
                  scan_in.mode      = MODE_UNK;
                  scan_in.begin_pos = pos_prev;
                  scan_in.cnt       = CW'(2);
               end
            end
         end
         MODE_LEADDOT: begin
            if (is_digit) begin
               scan_in.mant = acc_mant;
               scan_in.ovf  = acc_sat;
               scan_in.frac = CW'(1);
               scan_in.cnt  = CW'(2);
               scan_in.mode = MODE_FRAC;
            end else begin
               unk_path = 1'b1;
            end
         end
         MODE_ALPHA: begin
            if (is_letter && scan_ff.cnt < CW'(2)) begin
               scan_in.prefix = {scan_ff.prefix[7:0], char_code};
               scan_in.cnt    = CW'(2);
            end else if (is_letter && word_valid) begin
               tok0         = mk_tok(word_kind, scan_ff.begin_pos, CW'(3));
               tok_count    = 2'd1;
               scan_in.mode = MODE_IDLE;
            end else begin
               unk_path = 1'b1;
            end
         end
         default: begin
            unk_path = 1'b1;
         end
      endcase

      if (unk_path) begin
         if (is_blank_end) begin
            tok0      = mk_tok(aet_pkg::KIND_UNKNOWN, scan_ff.begin_pos, scan_ff.cnt);
            tok1      = r_tok;
            tok_count = 2'd1 + {1'b0, r_valid};
            scan_in   = restart;
            line_end  = r_end;
         end else if (cnt_plus >= LEX_LIMIT) begin
            tok0         = mk_tok(aet_pkg::KIND_UNKNOWN, scan_ff.begin_pos, cnt_plus);
            tok_count    = 2'd1;
            scan_in.mode = MODE_IDLE;
         end else begin
            scan_in.mode = MODE_UNK;
            scan_in.cnt  = cnt_plus;
         end
      end
   end

   assign pos_in = line_end ? '0 : pos_ff + POSITION_BITS'(1);

   // all-zero scan state is idle between tokens
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         pos_ff  <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         if (line_end) begin
            scan_ff <= '0;
         end else begin
            scan_ff <= scan_in;
         end
      end
   end

   always_comb begin
      run           = '0;
      run.count     = tok_count;
      run.tok[0]    = tok0;
      run.tok[1]    = tok1;
      run.tok[2]    = tok2;
      run.mantissa  = scan_ff.mant;
      run.fraction  = 5'(scan_ff.frac);
      run.saturated = scan_ff.ovf;
   end

   assign run_push = accept && (tok_count != 2'd0);

   a_line_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && char_code == CHAR_NUL) |=> (pos_ff == '0 && scan_ff.mode == MODE_IDLE))
      else $error("scanner not back at line start after end of line");

endmodule

`default_nettype wire

>>> hw/rtl/aet_queue.sv
// short queue of token runs between the scanner and the output stage
// depends on aet_pkg
`default_nettype none

module aet_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire aet_pkg::run_type  push_data,
   input  wire logic              pop,
   output aet_pkg::run_type       head,
   output logic                   full,
   output logic                   empty
);

   aet_pkg::run_type                       store_ff [aet_pkg::QUEUE_DEPTH];
   logic [aet_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [aet_pkg::QUEUE_COUNT_BITS-1:0]   count_ff, count_in;

   assign full  = (count_ff == aet_pkg::QUEUE_COUNT_BITS'(aet_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + aet_pkg::QUEUE_COUNT_BITS'(1);
         2'b01:   count_in = count_ff - aet_pkg::QUEUE_COUNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + aet_pkg::QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + aet_pkg::QUEUE_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("run pushed into a full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("run taken from an empty queue");

endmodule

`default_nettype wire

>>> hw/rtl/aet_back.sv
// output stage: holds one run and hands its tokens out one item at a time
// depends on aet_pkg
`default_nettype none

module aet_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire aet_pkg::run_type  head,
   input  wire logic              head_valid,
   output logic                   head_take,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [3:0]             rsp_token_kind,
   output logic [15:0]            rsp_token_start,
   output logic [4:0]             rsp_token_length,
   output logic [63:0]            rsp_number_mantissa,
   output logic [4:0]             rsp_fraction_digits,
   output logic                   rsp_mantissa_saturated,
   output logic                   rsp_last_of_run
);

   aet_pkg::run_type  cur_ff;
   logic              cur_valid_ff;
   logic [1:0]        idx_ff;

   aet_pkg::tok_type  tok;
   logic              fire, last, free, is_num;

   always_comb begin
      case (idx_ff)
         2'd0:    tok = cur_ff.tok[0];
         2'd1:    tok = cur_ff.tok[1];
         default: tok = cur_ff.tok[2];
      endcase
   end

   assign fire      = rsp_pop && cur_valid_ff;
   assign last      = (idx_ff == cur_ff.count - 2'd1);
   assign free      = !cur_valid_ff || (fire && last);
   assign head_take = free && head_valid;
   assign is_num    = (tok.kind == aet_pkg::KIND_NUMBER);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (head_take) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= 2'd0;
      end else if (fire && last) begin
         cur_valid_ff <= 1'b0;
      end else if (fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) begin
         cur_ff <= head;
      end
   end

   assign rsp_empty              = !cur_valid_ff;
   assign rsp_token_kind         = tok.kind;
   assign rsp_token_start        = tok.start;
   assign rsp_token_length       = tok.length;
   assign rsp_number_mantissa    = is_num ? cur_ff.mantissa : '0;
   assign rsp_fraction_digits    = is_num ? cur_ff.fraction : '0;
   assign rsp_mantissa_saturated = is_num && cur_ff.saturated;
   assign rsp_last_of_run        = last;

   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.count != 2'd0 && idx_ff < cur_ff.count))
      else $error("token index outside the held run");

endmodule

`default_nettype wire

>>> hw/rtl/arith_expression_tokenizer_core.sv
// arithmetic expression tokenizer: one character per cycle in, one token per cycle out
// a character is taken every cycle while the four-run queue has room; a character that
// yields k tokens (at most three) hands them out one at a time, each on an rsp_pop
// a character's first token passes the run queue, then the output stage's run register
// synchronous reset returns the scanner to position 0 of a new line and empties all queues
`default_nettype none

module arith_expression_tokenizer_core #(
   parameter int MAX_LEXEME    = 32,
   parameter int POSITION_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [7:0]    req_char_code,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [3:0]         rsp_token_kind,
   output logic [15:0]        rsp_token_start,
   output logic [4:0]         rsp_token_length,
   output logic [63:0]        rsp_number_mantissa,
   output logic [4:0]         rsp_fraction_digits,
   output logic               rsp_mantissa_saturated,
   output logic               rsp_last_of_run
);

   logic              accept;
   aet_pkg::run_type  run;
   logic              run_push;
   aet_pkg::run_type  head;
   logic              q_empty;
   logic              head_take;

   assign accept = req_push && !req_full;

   aet_front #(
      .MAX_LEXEME    (MAX_LEXEME),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .run       (run),
      .run_push  (run_push)
   );

   aet_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (run_push),
      .push_data (run),
      .pop       (head_take),
      .head      (head),
      .full      (req_full),
      .empty     (q_empty)
   );

   aet_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head                   (head),
      .head_valid             (!q_empty),
      .head_take              (head_take),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_token_kind         (rsp_token_kind),
      .rsp_token_start        (rsp_token_start),
      .rsp_token_length       (rsp_token_length),
      .rsp_number_mantissa    (rsp_number_mantissa),
      .rsp_fraction_digits    (rsp_fraction_digits),
      .rsp_mantissa_saturated (rsp_mantissa_saturated),
      .rsp_last_of_run        (rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// testbench for arith_expression_tokenizer_core: directed and random character lines with a
// token predictor, random stalls on both queues. depends on aet_pkg and the core rtl
`timescale 1ns / 100ps

module tb_top;

   localparam int LEXEME_MAX = 32;
   localparam int POS_BITS   = 16;

   typedef enum logic [2:0] {
      LX_IDLE, LX_INT, LX_DOTWAIT, LX_LEADDOT, LX_FRAC, LX_ALPHA, LX_UNK
   } lex_mode_type;

   typedef struct packed {
      aet_pkg::kind_type kind;
      logic [15:0]       start;
      logic [4:0]        length;
      logic [63:0]       mantissa;
      logic [4:0]        fraction;
      logic              saturated;
      logic              last;
   } token_rec_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          pin;
      token_rec_type tok;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_char_code;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [4:0]  rsp_token_length;
   logic [63:0] rsp_number_mantissa;
   logic [4:0]  rsp_fraction_digits;
   logic        rsp_mantissa_saturated;
   logic        rsp_last_of_run;

   // lexer state of the predictor
   lex_mode_type lex_mode;
   logic [15:0]  line_pos;
   logic [15:0]  tok_begin;
   int unsigned  lex_len;
   logic [15:0]  letters;
   logic [63:0]  mant;
   int unsigned  frac_cnt;
   logic         mant_sat;

   token_rec_type step_toks[$];
   token_rec_type pending_tokens[$];
   stim_row_type  directed_rows[$];
   logic [7:0]    line_buf[$];

   logic          pin_row;
   token_rec_type pin_token;
   logic          sender_steady = 1'b0;
   logic          reader_steady = 1'b0;
   int            mismatch_count = 0;

   arith_expression_tokenizer_core #(
      .MAX_LEXEME(LEXEME_MAX),
      .POSITION_BITS(POS_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_char_code(req_char_code),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_token_kind(rsp_token_kind),
      .rsp_token_start(rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_number_mantissa(rsp_number_mantissa),
      .rsp_fraction_digits(rsp_fraction_digits),
      .rsp_mantissa_saturated(rsp_mantissa_saturated),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #6 clock = ~clock;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit symbol_of(input logic [7:0] c, output aet_pkg::kind_type k);
      k = aet_pkg::KIND_UNKNOWN;
      case (c)
         "(": k = aet_pkg::KIND_LPAREN;
         ")": k = aet_pkg::KIND_RPAREN;
         "+": k = aet_pkg::KIND_PLUS;
         "-": k = aet_pkg::KIND_MINUS;
         "*": k = aet_pkg::KIND_MUL;
         "/": k = aet_pkg::KIND_DIV;
         "^": k = aet_pkg::KIND_POW;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic aet_pkg::kind_type word_kind(input logic [23:0] w);
      if (w == "sin") return aet_pkg::KIND_SIN;
      if (w == "cos") return aet_pkg::KIND_COS;
      if (w == "tan") return aet_pkg::KIND_TAN;
      return aet_pkg::KIND_UNKNOWN;
   endfunction

   function automatic void reset_lexer();
      lex_mode  = LX_IDLE;
      line_pos  = '0;
      tok_begin = '0;
      lex_len   = 0;
      letters   = '0;
      mant      = '0;
      frac_cnt  = 0;
      mant_sat  = 1'b0;
   endfunction

   function automatic void begin_token(input logic [15:0] p);
      tok_begin = p;
      lex_len   = 0;
      mant      = '0;
      frac_cnt  = 0;
      mant_sat  = 1'b0;
      letters   = '0;
   endfunction

   function automatic void restart_at_dot(input logic [15:0] p);
      begin_token(p);
      lex_len  = 1;
      lex_mode = LX_LEADDOT;
   endfunction

   function automatic void add_digit(input logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - "0");
      if (mant_sat || mant > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
         mant     = '1;
         mant_sat = 1'b1;
      end else begin
         mant = mant * 64'd10 + d;
      end
   endfunction

   function automatic void push_token(input aet_pkg::kind_type k, input logic [15:0] s,
                                      input int unsigned len, input logic [63:0] m,
                                      input int unsigned f, input logic sat);
      if (step_toks.size() < aet_pkg::RUN_SLOTS)
         step_toks.push_back('{k, s, 5'(len), m, 5'(f), sat, 1'b0});
   endfunction

   // tokens caused by one character, left in step_toks
   function automatic void tokenize_char(input logic [7:0] c);
      logic [15:0]       pos;
      bit                done;
      bit                eol;
      aet_pkg::kind_type k;
      token_rec_type     t;
      pos  = line_pos;
      done = 1'b0;
      eol  = 1'b0;
      step_toks.delete();
      while (!done) begin
         case (lex_mode)
            LX_IDLE: begin
               if (c == 8'd0) begin
                  push_token(aet_pkg::KIND_END, pos, 0, '0, 0, 1'b0);
                  eol  = 1'b1;
                  done = 1'b1;
               end else if (c == " ") begin
                  done = 1'b1;
               end else begin
                  begin_token(pos);
                  if (is_digit(c)) begin
                     add_digit(c);
                     lex_len  = 1;
                     lex_mode = LX_INT;
                     done     = 1'b1;
                  end else if (c == ".") begin
                     lex_len  = 1;
                     lex_mode = LX_LEADDOT;
                     done     = 1'b1;
                  end else if (symbol_of(c, k)) begin
                     push_token(k, pos, 1, '0, 0, 1'b0);
                     done = 1'b1;
                  end else if (is_letter(c)) begin
                     letters  = {8'd0, c};
                     lex_len  = 1;
                     lex_mode = LX_ALPHA;
                     done     = 1'b1;
                  end else begin
                     lex_mode = LX_UNK;
                  end
               end
            end
            LX_INT, LX_FRAC: begin
               if (is_digit(c)) begin
                  if (lex_len >= LEXEME_MAX - 1) begin
                     push_token(aet_pkg::KIND_UNKNOWN, tok_begin, LEXEME_MAX - 1, '0, 0, 1'b0);
                     lex_mode = LX_IDLE;
                  end else begin
                     add_digit(c);
                     lex_len++;
                     if (lex_mode == LX_FRAC)
                        frac_cnt++;
                     done = 1'b1;
                  end
               end else if (c == "." && lex_mode == LX_INT) begin
                  lex_mode = LX_DOTWAIT;
                  done     = 1'b1;
               end else begin
                  push_token(aet_pkg::KIND_NUMBER, tok_begin, lex_len, mant, frac_cnt,
                             mant_sat);
                  lex_mode = LX_IDLE;
               end
            end
            LX_DOTWAIT: begin
               if (is_digit(c) && lex_len + 2 <= LEXEME_MAX - 1) begin
                  add_digit(c);
                  frac_cnt = 1;
                  lex_len  = lex_len + 2;
                  lex_mode = LX_FRAC;
                  done     = 1'b1;
               end else if (is_digit(c)) begin
                  push_token(aet_pkg::KIND_UNKNOWN, tok_begin, LEXEME_MAX - 1, '0, 0, 1'b0);
                  lex_mode = LX_IDLE;
                  if (lex_len >= LEXEME_MAX - 1)
                     restart_at_dot(pos - 16'd1);
               end else begin
                  push_token(aet_pkg::KIND_NUMBER, tok_begin, lex_len, mant, frac_cnt,
                             mant_sat);
                  restart_at_dot(pos - 16'd1);
               end
            end
            LX_LEADDOT: begin
               if (is_digit(c)) begin
                  add_digit(c);
                  frac_cnt = 1;
                  lex_len  = 2;
                  lex_mode = LX_FRAC;
                  done     = 1'b1;
               end else begin
                  lex_mode = LX_UNK;
               end
            end
            LX_ALPHA: begin
               if (is_letter(c) && lex_len < 2) begin
                  letters = {letters[7:0], c};
                  lex_len = 2;
                  done    = 1'b1;
               end else if (is_letter(c) &&
                            word_kind({letters, c}) != aet_pkg::KIND_UNKNOWN) begin
                  push_token(word_kind({letters, c}), tok_begin, 3, '0, 0, 1'b0);
                  lex_mode = LX_IDLE;
                  done     = 1'b1;
               end else begin
                  lex_mode = LX_UNK;
               end
            end
            default: begin
               if (c == 8'd0 || c == " ") begin
                  push_token(aet_pkg::KIND_UNKNOWN, tok_begin, lex_len, '0, 0, 1'b0);
                  lex_mode = LX_IDLE;
               end else begin
                  lex_len++;
                  if (lex_len >= LEXEME_MAX - 1) begin
                     push_token(aet_pkg::KIND_UNKNOWN, tok_begin, lex_len, '0, 0, 1'b0);
                     lex_mode = LX_IDLE;
                  end
                  done = 1'b1;
               end
            end
         endcase
      end
      if (eol)
         reset_lexer();
      else
         line_pos = line_pos + 16'd1;
      if (step_toks.size() > 0) begin
         t = step_toks.pop_back();
         t.last = 1'b1;
         step_toks.push_back(t);
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      token_rec_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_tokens.size() == 0) begin
               mismatch_count++;
               $error("token_kind: expected none, got %0d at %0d",
                      rsp_token_kind, rsp_token_start);
            end else begin
               want = pending_tokens.pop_front();
               check_field("token_kind", want.kind, rsp_token_kind);
               check_field("token_start", want.start, rsp_token_start);
               check_field("token_length", want.length, rsp_token_length);
               check_field("number_mantissa", want.mantissa, rsp_number_mantissa);
               check_field("fraction_digits", want.fraction, rsp_fraction_digits);
               check_field("mantissa_saturated", want.saturated, rsp_mantissa_saturated);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
         if (req_push && !req_full) begin
            tokenize_char(req_char_code);
            if (pin_row)
               pending_tokens.push_back(pin_token);
            else
               foreach (step_toks[i])
                  pending_tokens.push_back(step_toks[i]);
         end
      end
   end

   // stretches with and without stalls on both sides
   initial forever begin
      repeat ($urandom_range(50, 300)) @(posedge clock);
      sender_steady <= ($urandom_range(0, 3) == 0);
      reader_steady <= ($urandom_range(0, 3) == 0);
   end

   initial begin : reader
      int gap;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = reader_steady ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop = 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic send_char(input logic [7:0] c, input logic pin, input token_rec_type tok,
                            input bit hurry);
      int gap;
      gap = (hurry || sender_steady) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push      = 1'b1;
      req_char_code = c;
      pin_row       = pin;
      pin_token     = tok;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained(input int limit);
      int n;
      n = 0;
      req_push = 1'b0;
      do begin
         @(negedge clock);
         n++;
      end while (pending_tokens.size() != 0 && n < limit);
   endtask

   function automatic void add_row(input logic [7:0] c, input logic pin = 1'b0,
                                   input aet_pkg::kind_type k = aet_pkg::KIND_END,
                                   input int s = 0, input int len = 0);
      directed_rows.push_back('{c, pin, '{k, 16'(s), 5'(len), 64'd0, 5'd0, 1'b0, 1'b1}});
   endfunction

   function automatic void add_digits(input int n);
      repeat (n) line_buf.push_back(8'($urandom_range(48, 57)));
   endfunction

   function automatic void add_fragment();
      string symbols;
      string words;
      int    sel;
      int    n;
      int    w;
      int    form;
      symbols = "()+-*/^";
      words   = "sincostan";
      sel     = $urandom_range(0, 99);
      if (sel < 35) begin
         form = $urandom_range(0, 19);
         n = (form < 14) ? $urandom_range(1, 4) :
             (form < 17) ? $urandom_range(18, 24) : $urandom_range(28, 34);
         form = $urandom_range(0, 3);
         if (form == 2) begin
            line_buf.push_back(".");
            add_digits(n);
         end else begin
            add_digits(n);
            if (form != 0)
               line_buf.push_back(".");
            if (form == 1)
               add_digits($urandom_range(0, 5) == 0 ? $urandom_range(5, 30) :
                          $urandom_range(1, 3));
         end
      end else if (sel < 55) begin
         line_buf.push_back(symbols[$urandom_range(0, 6)]);
      end else if (sel < 75) begin
         w    = 3 * $urandom_range(0, 2);
         form = $urandom_range(0, 9);
         if (form == 9) begin
            repeat ($urandom_range(1, 4))
               line_buf.push_back(8'($urandom_range(0, 1) ? $urandom_range(97, 122) :
                                     $urandom_range(65, 90)));
         end else if (form == 6) begin
            for (int i = 0; i < $urandom_range(1, 2); i++)
               line_buf.push_back(words[w + i]);
         end else begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
               line_buf.push_back((form == 7 && i == n) ?
                                  8'($urandom_range(0, 1) ? $urandom_range(97, 122) :
                                     $urandom_range(65, 90)) : words[w + i]);
            if (form == 8)
               line_buf.push_back(8'($urandom_range(97, 122)));
         end
      end else if (sel < 88) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 4);
         line_buf.push_back(8'($urandom_range(0, 1) ? $urandom_range(33, 39) :
                               $urandom_range(128, 255)));
         repeat (n - 1) begin
            w = $urandom_range(1, 255);
            line_buf.push_back(w == 32 ? 8'd33 : 8'(w));
         end
      end else begin
         line_buf.push_back(8'($urandom_range(1, 255)));
      end
      sel = $urandom_range(0, 9);
      if (sel < 5)
         line_buf.push_back(" ");
      else if (sel >= 7)
         repeat ($urandom_range(2, 3)) line_buf.push_back(" ");
   endfunction

   function automatic void build_line(input int fragments);
      line_buf.delete();
      repeat (fragments) add_fragment();
      line_buf.push_back(8'd0);
   endfunction

   initial begin
      token_rec_type blank;
      int unsigned   chars_sent;
      int            line_no;
      blank         = '0;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_char_code = 8'd0;
      pin_row       = 1'b0;
      pin_token     = '0;
      reset_lexer();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(8'd0, 1'b1, aet_pkg::KIND_END, 0, 0);
      add_row("(", 1'b1, aet_pkg::KIND_LPAREN, 0, 1);
      add_row(" ");
      add_row("9");
      add_row(".");
      add_row("5");
      add_row("^");
      add_row("s");
      add_row("i");
      add_row("n");
      add_row("7");
      add_row(".");
      add_row("/");
      add_row(8'hFF);
      add_row(" ");
      add_row("t");
      add_row("a");
      add_row("n");
      add_row("c");
      add_row("o");
      add_row("s");
      add_row("-", 1'b1, aet_pkg::KIND_MINUS, 20, 1);
      add_row(")", 1'b1, aet_pkg::KIND_RPAREN, 21, 1);
      add_row("*", 1'b1, aet_pkg::KIND_MUL, 22, 1);
      add_row("/", 1'b1, aet_pkg::KIND_DIV, 23, 1);
      add_row("+", 1'b1, aet_pkg::KIND_PLUS, 24, 1);
      add_row(8'd0, 1'b1, aet_pkg::KIND_END, 25, 0);
      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].pin, directed_rows[i].tok, 1'b0);
      wait_drained(20000);

      chars_sent = 0;
      line_no    = 0;
      while (chars_sent < 280) begin
         build_line($urandom_range(1, 10));
         foreach (line_buf[i]) begin
            send_char(line_buf[i], 1'b0, blank, 1'b0);
            chars_sent++;
         end
         line_no++;
         if (line_no % 5 == 0)
            wait_drained(20000);
      end

      wait_drained(20000);
      if (pending_tokens.size() != 0) begin
         mismatch_count++;
         $error("token_kind: expected %0d more tokens, got none", pending_tokens.size());
      end
      repeat (12) @(negedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/aet_pkg.sv
hw/rtl/aet_front.sv
hw/rtl/aet_queue.sv
hw/rtl/aet_back.sv
hw/rtl/arith_expression_tokenizer_core.sv
tb/tb_top.sv
